// ----- rtl/core/kvct_pkg.sv -----
// Shared types, codes and character constants of the key/value command tokenizer.
package kvct_pkg;

  // Parser modes.
  localparam logic [2:0] MODE_BETWEEN  = 3'd0;
  localparam logic [2:0] MODE_KEY      = 3'd1;
  localparam logic [2:0] MODE_AFTER_EQ = 3'd2;
  localparam logic [2:0] MODE_UVAL     = 3'd3;
  localparam logic [2:0] MODE_QVAL     = 3'd4;

  // Progress of the key against the literal "mid".
  localparam logic [2:0] KM_EMPTY = 3'd0;
  localparam logic [2:0] KM_MID   = 3'd3;
  localparam logic [2:0] KM_OTHER = 3'd4;

  // Phases of the decimal number reader.
  localparam logic [1:0] NUM_SPACE  = 2'd0;
  localparam logic [1:0] NUM_DIGITS = 2'd1;
  localparam logic [1:0] NUM_DONE   = 2'd2;

  // Byte roles.
  localparam logic [1:0] ROLE_SEP   = 2'd0;
  localparam logic [1:0] ROLE_KEY   = 2'd1;
  localparam logic [1:0] ROLE_VALUE = 2'd2;
  localparam logic [1:0] ROLE_END   = 2'd3;

  // Characters the parser looks for.
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_LC_D  = 8'h64;
  localparam logic [7:0] CHAR_LC_I  = 8'h69;
  localparam logic [7:0] CHAR_LC_M  = 8'h6D;

  // Width of the index and count fields on the result channel.
  localparam int IdxW = 4;

  // Parser state that does not depend on the parameter count limit.
  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  key_match;
    logic [31:0] id_accum;
    logic        id_negative;
    logic [1:0]  number_phase;
    logic        error_seen;
    logic [31:0] message_id;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '0;

  // One result of the parser.
  typedef struct packed {
    logic [1:0]        byte_role;
    logic [IdxW-1:0]   param_index;
    logic              param_closed;
    logic              param_withdrawn;
    logic              line_done;
    logic              line_error;
    logic [IdxW-1:0]   param_count;
    logic signed [31:0] message_id;
  } result_t;

endpackage

// ----- rtl/core/kvct_in_if.sv -----
// Input channel of the tokenizer: one line byte per request.
interface kvct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink (input valid, input char_byte, output ready);
endinterface

// ----- rtl/core/kvct_out_if.sv -----
// Result channel of the tokenizer: one result per line byte.
interface kvct_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         byte_role;
  logic [3:0]         param_index;
  logic               param_closed;
  logic               param_withdrawn;
  logic               line_done;
  logic               line_error;
  logic [3:0]         param_count;
  logic signed [31:0] message_id;

  modport source (output valid, output byte_role, output param_index, output param_closed,
                  output param_withdrawn, output line_done, output line_error,
                  output param_count, output message_id, input ready);
  modport sink (input valid, input byte_role, input param_index, input param_closed,
                input param_withdrawn, input line_done, input line_error,
                input param_count, input message_id, output ready);
endinterface

// ----- rtl/core/key_value_command_tokenizer_unit.sv -----
// Top level of the key/value command tokenizer.
//
// The chars channel takes one command-line byte per request; a zero byte
// ends the line. The tokens channel returns exactly one result per byte, in
// order: the byte's role, its parameter index, whether it closed a kept or a
// withdrawn ("mid") parameter, and, on the terminating zero, the line status,
// the kept parameter count and the last message id.
//
// A byte accepted into the input register is parsed into the result register,
// from which its result is offered. The block takes one byte every cycle
// while the receiver takes results; the parser state loop is combinational
// logic between the input register and the result register.
//
// Reset clears both registers' valid flags and the parser state, which
// starts between parameters of an empty line. When the receiver holds ready
// low, the result register holds its request and the input register keeps
// one more byte; after that chars.ready falls until the result is taken.
module key_value_command_tokenizer_unit import kvct_pkg::*; #(
  parameter int MAX_PARAMS = 16
) (
  input  logic       clk,
  input  logic       rst,
  kvct_in_if.sink    chars,
  kvct_out_if.source tokens
);

  localparam int CntW = $clog2(MAX_PARAMS + 1);

  logic            stage_valid;
  logic [7:0]      stage_byte;
  logic            out_valid;
  result_t         out_result;
  parse_state_t    state;
  parse_state_t    state_next;
  logic [CntW-1:0] kept_count;
  logic [CntW-1:0] kept_count_next;
  result_t         result;
  logic            advance;
  logic            step;

  // Pipeline flow: the result register moves when empty or taken.
  assign advance     = !out_valid || tokens.ready;
  assign step        = stage_valid && advance;
  assign chars.ready = !stage_valid || advance;

  kvct_parse #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_parse (
    .state           (state),
    .kept_count      (kept_count),
    .char_byte       (stage_byte),
    .state_next      (state_next),
    .kept_count_next (kept_count_next),
    .result          (result)
  );

  // Control and parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
      state       <= STATE_RESET;
      kept_count  <= '0;
    end else begin
      if (chars.ready) begin
        stage_valid <= chars.valid;
      end
      if (advance) begin
        out_valid <= stage_valid;
      end
      if (step) begin
        state      <= state_next;
        kept_count <= kept_count_next;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      stage_byte <= chars.char_byte;
    end
    if (step) begin
      out_result <= result;
    end
  end

  assign tokens.valid           = out_valid;
  assign tokens.byte_role       = out_result.byte_role;
  assign tokens.param_index     = out_result.param_index;
  assign tokens.param_closed    = out_result.param_closed;
  assign tokens.param_withdrawn = out_result.param_withdrawn;
  assign tokens.line_done       = out_result.line_done;
  assign tokens.line_error      = out_result.line_error;
  assign tokens.param_count     = out_result.param_count;
  assign tokens.message_id      = out_result.message_id;

  // A byte never both keeps and withdraws a parameter.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_result.param_closed && out_result.param_withdrawn))
    else $error("result both closes and withdraws a parameter");

  // Line status fields are only set on the line end, and an error carries no count.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_result.line_done) |->
      (!out_result.line_error && out_result.param_count == '0 &&
       out_result.message_id == '0))
    else $error("line status set on a byte that is not the line end");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_result.line_error) |-> out_result.param_count == '0)
    else $error("erroneous line reports a parameter count");

  // The kept count never passes the limit.
  assert property (@(posedge clk) disable iff (rst)
    int'(kept_count) <= MAX_PARAMS)
    else $error("kept parameter count beyond the limit");

  // A line end leaves the parser in its fresh-line state.
  assert property (@(posedge clk) disable iff (rst)
    (step && stage_byte == CHAR_NUL) |=>
      (kept_count == '0 && state == STATE_RESET))
    else $error("parser state not cleared after line end");

endmodule

// ----- rtl/core/kvct_parse.sv -----
// Next-state and result logic of the tokenizer for one line byte.
module kvct_parse import kvct_pkg::*; #(
  parameter int  MAX_PARAMS = 16,
  localparam int CntW = $clog2(MAX_PARAMS + 1)
) (
  input  parse_state_t    state,
  input  logic [CntW-1:0] kept_count,
  input  logic [7:0]      char_byte,
  output parse_state_t    state_next,
  output logic [CntW-1:0] kept_count_next,
  output result_t         result
);

  // Match one more key byte against "mid".
  function automatic logic [2:0] key_feed(logic [2:0] km, logic [7:0] c);
    logic [7:0] want;
    case (km)
      3'd0:    want = CHAR_LC_M;
      3'd1:    want = CHAR_LC_I;
      default: want = CHAR_LC_D;
    endcase
    if (km < KM_MID && c == want) begin
      key_feed = km + 3'd1;
    end else begin
      key_feed = KM_OTHER;
    end
  endfunction

  // Feed one value byte into the signed decimal reader.
  function automatic parse_state_t number_feed(parse_state_t s, logic [7:0] c);
    parse_state_t r;
    logic         digit;
    logic [31:0]  dval;
    r     = s;
    digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    dval  = 32'(c - CHAR_ZERO);
    case (s.number_phase)
      NUM_SPACE: begin
        if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
          r.number_phase = NUM_SPACE;
        end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
          r.id_negative  = (c == CHAR_MINUS);
          r.number_phase = NUM_DIGITS;
        end else if (digit) begin
          r.id_accum     = dval;
          r.number_phase = NUM_DIGITS;
        end else begin
          r.number_phase = NUM_DONE;
        end
      end
      NUM_DIGITS: begin
        if (digit) begin
          r.id_accum = (s.id_accum << 3) + (s.id_accum << 1) + dval;
        end else begin
          r.number_phase = NUM_DONE;
        end
      end
      default: r.number_phase = s.number_phase;
    endcase
    number_feed = r;
  endfunction

  logic            is_nul;
  logic            is_space;
  logic            is_eq;
  logic            is_quote;
  logic            close_kept;
  logic            close_valued;
  logic            set_error;
  logic            withdrawn;
  logic [1:0]      role;
  logic [CntW-1:0] kept_inc;
  logic            max_hit;
  parse_state_t    nx;
  logic [CntW-1:0] kept_nx;

  assign is_nul   = (char_byte == CHAR_NUL);
  assign is_space = (char_byte == CHAR_SPACE);
  assign is_eq    = (char_byte == CHAR_EQ);
  assign is_quote = (char_byte == CHAR_QUOTE);
  assign kept_inc = kept_count + 1'b1;
  assign max_hit  = (int'(kept_inc) >= MAX_PARAMS);

  // Mode decisions, then parameter closing, then the end-of-line wrap-up.
  always_comb begin
    nx           = state;
    kept_nx      = kept_count;
    role         = ROLE_SEP;
    close_kept   = 1'b0;
    close_valued = 1'b0;
    set_error    = 1'b0;
    withdrawn    = 1'b0;

    if (state.error_seen) begin
      role = ROLE_END;
    end else begin
      case (state.mode)
        MODE_BETWEEN: begin
          if (is_nul) begin
            role = ROLE_END;
          end else if (is_eq) begin
            nx.key_match    = KM_EMPTY;
            nx.id_accum     = '0;
            nx.id_negative  = 1'b0;
            nx.number_phase = NUM_SPACE;
            nx.mode         = MODE_AFTER_EQ;
          end else if (!is_space) begin
            nx.key_match = key_feed(KM_EMPTY, char_byte);
            role         = ROLE_KEY;
            nx.mode      = MODE_KEY;
          end
        end
        MODE_KEY: begin
          if (is_nul || is_space) begin
            role       = is_nul ? ROLE_END : ROLE_SEP;
            close_kept = 1'b1;
            nx.mode    = MODE_BETWEEN;
          end else if (is_eq) begin
            nx.id_accum     = '0;
            nx.id_negative  = 1'b0;
            nx.number_phase = NUM_SPACE;
            nx.mode         = MODE_AFTER_EQ;
          end else begin
            nx.key_match = key_feed(state.key_match, char_byte);
            role         = ROLE_KEY;
          end
        end
        MODE_AFTER_EQ: begin
          if (is_nul || is_space || char_byte == CHAR_SEMI) begin
            role      = ROLE_END;
            set_error = 1'b1;
          end else if (is_quote) begin
            nx.mode = MODE_QVAL;
          end else if (is_eq) begin
            close_valued = 1'b1;
          end else begin
            nx      = number_feed(state, char_byte);
            role    = ROLE_VALUE;
            nx.mode = MODE_UVAL;
          end
        end
        MODE_UVAL: begin
          if (is_nul || is_space || is_eq) begin
            role         = is_nul ? ROLE_END : ROLE_SEP;
            close_valued = 1'b1;
          end else begin
            nx   = number_feed(state, char_byte);
            role = ROLE_VALUE;
          end
        end
        default: begin
          // Quoted value; codes that are never used behave the same way.
          if (is_nul) begin
            role      = ROLE_END;
            set_error = 1'b1;
          end else if (is_quote) begin
            close_valued = 1'b1;
          end else begin
            nx   = number_feed(state, char_byte);
            role = ROLE_VALUE;
          end
        end
      endcase
    end

    // A valued "mid" parameter is withdrawn, anything else is kept.
    if (close_valued) begin
      if (state.key_match == KM_MID) begin
        nx.message_id = state.id_negative ? (32'd0 - state.id_accum) : state.id_accum;
        withdrawn     = 1'b1;
      end else begin
        close_kept = 1'b1;
      end
      nx.mode = MODE_BETWEEN;
    end

    if (close_kept) begin
      kept_nx = kept_inc;
      if (max_hit) begin
        set_error = 1'b1;
      end
    end

    if (set_error) begin
      nx.error_seen = 1'b1;
    end

    result.byte_role       = role;
    result.param_index     = IdxW'(kept_count);
    result.param_closed    = close_kept;
    result.param_withdrawn = withdrawn;
    result.line_done       = is_nul;
    result.line_error      = is_nul && nx.error_seen;
    result.param_count     = (is_nul && !nx.error_seen) ? IdxW'(kept_nx) : '0;
    result.message_id      = is_nul ? nx.message_id : '0;

    // The terminating zero starts a fresh line.
    if (is_nul) begin
      nx      = STATE_RESET;
      kept_nx = '0;
    end

    state_next      = nx;
    kept_count_next = kept_nx;
  end

endmodule
